>>> design/slfp_pkg.sv
// shared types, constants and helper functions of the sync/length frame parser
// used by every module in this folder; depends on nothing else

package slfp_pkg;

	localparam int SIG_MAX_BYTES       = 4;
	localparam int LEN_FIELD_MAX_BYTES = 8;

	localparam int BYTE_W    = 8;
	localparam int SIG_W     = SIG_MAX_BYTES * BYTE_W;
	localparam int SIG_N_W   = $clog2(SIG_MAX_BYTES + 1);
	localparam int LEN_W     = 64;
	localparam int LEN_N_W   = 4;
	localparam int SEEN_W    = 4;

	localparam int SIG_VALUE_W       = 32;
	localparam int SIG_LEN_W         = 3;
	localparam int LEN_FIELD_BYTES_W = 4;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;
	localparam int REG_IDX_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_SIG_VALUE       = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SIG_LEN         = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_LEN_FIELD_BYTES = 2'd2;

	localparam logic [SIG_LEN_W-1:0]         SIG_LEN_RESET         = 3'd1;
	localparam logic [LEN_FIELD_BYTES_W-1:0] LEN_FIELD_BYTES_RESET = 4'd4;

	typedef enum logic [1:0] {
		PH_HUNT   = 2'd0,
		PH_LENGTH = 2'd1,
		PH_DATA   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [SIG_VALUE_W-1:0]       sig_value;
		logic [SIG_LEN_W-1:0]         sig_len;
		logic [LEN_FIELD_BYTES_W-1:0] len_field_bytes;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] payload_byte;
		logic              first_of_message;
		logic              last_of_message;
	} res_t;

	// signature length forced into 1..SIG_MAX_BYTES
	function automatic logic [SIG_N_W-1:0] sig_count(input logic [SIG_LEN_W-1:0] v);
		logic [SIG_N_W-1:0] n;
		if (v == '0)
			n = SIG_N_W'(1);
		else if (32'(v) > SIG_MAX_BYTES)
			n = SIG_N_W'(SIG_MAX_BYTES);
		else
			n = SIG_N_W'(v);
		return n;
	endfunction

	// length field size forced into 1..LEN_FIELD_MAX_BYTES
	function automatic logic [LEN_N_W-1:0] len_count(input logic [LEN_FIELD_BYTES_W-1:0] v);
		logic [LEN_N_W-1:0] n;
		if (v == '0)
			n = LEN_N_W'(1);
		else if (32'(v) > LEN_FIELD_MAX_BYTES)
			n = LEN_N_W'(LEN_FIELD_MAX_BYTES);
		else
			n = LEN_N_W'(v);
		return n;
	endfunction

	function automatic logic [SIG_W-1:0] sig_mask(input logic [SIG_N_W-1:0] n);
		logic [SIG_W-1:0] m;
		for (int i = 0; i < SIG_MAX_BYTES; i++)
			m[i*BYTE_W +: BYTE_W] = (32'(n) > i) ? '1 : '0;
		return m;
	endfunction

	function automatic logic [LEN_W-1:0] len_mask(input logic [LEN_N_W-1:0] n);
		logic [LEN_W-1:0] m;
		for (int i = 0; i < LEN_W / BYTE_W; i++)
			m[i*BYTE_W +: BYTE_W] = (32'(n) > i) ? '1 : '0;
		return m;
	endfunction

endpackage

>>> design/slfp_cfg.sv
// apb register file: signature value, signature length, length field size
// depends on slfp_pkg

module slfp_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [slfp_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [slfp_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [slfp_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	output slfp_pkg::cfg_t                    cfg
);

	logic [slfp_pkg::SIG_VALUE_W-1:0]       sig_value_q;
	logic [slfp_pkg::SIG_LEN_W-1:0]         sig_len_q;
	logic [slfp_pkg::LEN_FIELD_BYTES_W-1:0] len_field_bytes_q;
	logic [slfp_pkg::REG_IDX_W-1:0]         reg_idx;
	logic                                   wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[slfp_pkg::APB_ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_value_q       <= '0;
			sig_len_q         <= slfp_pkg::SIG_LEN_RESET;
			len_field_bytes_q <= slfp_pkg::LEN_FIELD_BYTES_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				slfp_pkg::REG_SIG_VALUE: begin
					sig_value_q <= pwdata[slfp_pkg::SIG_VALUE_W-1:0];
				end
				slfp_pkg::REG_SIG_LEN: begin
					sig_len_q <= pwdata[slfp_pkg::SIG_LEN_W-1:0];
				end
				slfp_pkg::REG_LEN_FIELD_BYTES: begin
					len_field_bytes_q <= pwdata[slfp_pkg::LEN_FIELD_BYTES_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			slfp_pkg::REG_SIG_VALUE:       prdata = slfp_pkg::APB_DATA_W'(sig_value_q);
			slfp_pkg::REG_SIG_LEN:         prdata = slfp_pkg::APB_DATA_W'(sig_len_q);
			slfp_pkg::REG_LEN_FIELD_BYTES: prdata = slfp_pkg::APB_DATA_W'(len_field_bytes_q);
			default:                       prdata = '0;
		endcase
	end

	assign cfg.sig_value       = sig_value_q;
	assign cfg.sig_len         = sig_len_q;
	assign cfg.len_field_bytes = len_field_bytes_q;

endmodule

>>> design/slfp_in_reg.sv
// input register: holds one received byte until the parser core takes it
// depends on slfp_pkg

module slfp_in_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [slfp_pkg::BYTE_W-1:0]   s_tdata,
	input  logic                          advance,
	output logic                          valid_s1,
	output logic [slfp_pkg::BYTE_W-1:0]   byte_s1
);

	logic take;

	// free when empty or when the held item moves on this cycle
	assign s_tready = !valid_s1 || advance;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

>>> design/slfp_core.sv
// parser state machine: signature hunt, length collection, payload count
// depends on slfp_pkg; produces at most one result per processed byte

module slfp_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slfp_pkg::cfg_t                cfg,
	input  logic                          step_en,
	input  logic [slfp_pkg::BYTE_W-1:0]   rx_byte,
	output slfp_pkg::res_t                res
);

	slfp_pkg::phase_t                phase_q, phase_d;
	logic [slfp_pkg::SIG_W-1:0]      win_q, win_d, win_nx, win_mask;
	logic [slfp_pkg::SIG_N_W-1:0]    fill_q, fill_d, fill_nx, sig_n;
	logic [slfp_pkg::LEN_W-1:0]      accum_q, accum_d, accum_nx, len_val;
	logic [slfp_pkg::SEEN_W-1:0]     seen_q, seen_d, seen_nx;
	logic [slfp_pkg::LEN_N_W-1:0]    len_n;
	logic [slfp_pkg::LEN_W-1:0]      rem_q, rem_d;
	logic                            started_q, started_d;
	logic                            sig_match, len_done, len_zero, last;

	assign sig_n    = slfp_pkg::sig_count(cfg.sig_len);
	assign win_mask = slfp_pkg::sig_mask(sig_n);
	assign win_nx   = slfp_pkg::SIG_W'({win_q, rx_byte}) & win_mask;
	assign fill_nx  = (fill_q < sig_n) ? slfp_pkg::SIG_N_W'(fill_q + 1'b1) : fill_q;
	assign sig_match = (fill_nx >= sig_n) &&
		(win_nx == (slfp_pkg::SIG_W'(cfg.sig_value) & win_mask));

	assign len_n    = slfp_pkg::len_count(cfg.len_field_bytes);
	assign accum_nx = slfp_pkg::LEN_W'({accum_q, rx_byte});
	assign seen_nx  = (seen_q != '1) ? slfp_pkg::SEEN_W'(seen_q + 1'b1) : seen_q;
	assign len_done = (seen_nx >= len_n);
	assign len_val  = accum_nx & slfp_pkg::len_mask(len_n);
	assign len_zero = (len_val == '0);

	assign last = (rem_q <= slfp_pkg::LEN_W'(1));

	// next phase
	always_comb begin
		case (phase_q)
			slfp_pkg::PH_HUNT: begin
				phase_d = sig_match ? slfp_pkg::PH_LENGTH : slfp_pkg::PH_HUNT;
			end
			slfp_pkg::PH_LENGTH: begin
				if (len_done)
					phase_d = len_zero ? slfp_pkg::PH_HUNT : slfp_pkg::PH_DATA;
				else
					phase_d = slfp_pkg::PH_LENGTH;
			end
			slfp_pkg::PH_DATA: begin
				phase_d = last ? slfp_pkg::PH_HUNT : slfp_pkg::PH_DATA;
			end
			default: begin
				phase_d = slfp_pkg::PH_HUNT;
			end
		endcase
	end

	// datapath and result
	always_comb begin
		win_d     = win_q;
		fill_d    = fill_q;
		accum_d   = accum_q;
		seen_d    = seen_q;
		rem_d     = rem_q;
		started_d = started_q;
		res.valid            = 1'b0;
		res.payload_byte     = rx_byte;
		res.first_of_message = !started_q;
		res.last_of_message  = last;
		case (phase_q)
			slfp_pkg::PH_HUNT: begin
				win_d  = win_nx;
				fill_d = fill_nx;
				if (sig_match) begin
					win_d   = '0;
					fill_d  = '0;
					accum_d = '0;
					seen_d  = '0;
				end
			end
			slfp_pkg::PH_LENGTH: begin
				accum_d = accum_nx;
				seen_d  = seen_nx;
				if (len_done) begin
					win_d     = '0;
					fill_d    = '0;
					accum_d   = '0;
					seen_d    = '0;
					started_d = 1'b0;
					rem_d     = len_zero ? '0 : len_val;
				end
			end
			slfp_pkg::PH_DATA: begin
				res.valid = 1'b1;
				started_d = 1'b1;
				if (last) begin
					win_d     = '0;
					fill_d    = '0;
					accum_d   = '0;
					seen_d    = '0;
					rem_d     = '0;
					started_d = 1'b0;
				end else begin
					rem_d = rem_q - slfp_pkg::LEN_W'(1);
				end
			end
			default: begin
				win_d     = '0;
				fill_d    = '0;
				accum_d   = '0;
				seen_d    = '0;
				rem_d     = '0;
				started_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= slfp_pkg::PH_HUNT;
			win_q     <= '0;
			fill_q    <= '0;
			accum_q   <= '0;
			seen_q    <= '0;
			rem_q     <= '0;
			started_q <= 1'b0;
		end else if (step_en) begin
			phase_q   <= phase_d;
			win_q     <= win_d;
			fill_q    <= fill_d;
			accum_q   <= accum_d;
			seen_q    <= seen_d;
			rem_q     <= rem_d;
			started_q <= started_d;
		end
	end

	a_data_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == slfp_pkg::PH_DATA |-> rem_q != '0)
		else $error("payload phase with zero remaining count");

	a_last_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.valid && res.last_of_message |=> phase_q == slfp_pkg::PH_HUNT)
		else $error("no return to hunt after last payload byte");

	a_started_only_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != slfp_pkg::PH_DATA |-> !started_q)
		else $error("payload started flag set outside payload phase");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= slfp_pkg::SIG_MAX_BYTES)
		else $error("signature window fill count out of range");

endmodule

>>> design/slfp_out_reg.sv
// result register on the master side of the stream
// depends on slfp_pkg

module slfp_out_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slfp_pkg::res_t                res,
	input  logic                          advance,
	output logic                          out_free,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [slfp_pkg::BYTE_W-1:0]   m_tdata,
	output logic                          m_tuser,
	output logic                          m_tlast
);

	logic                        valid_q;
	logic [slfp_pkg::BYTE_W-1:0] data_q;
	logic                        first_q;
	logic                        last_q;

	assign out_free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res.valid;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			data_q  <= res.payload_byte;
			first_q <= res.first_of_message;
			last_q  <= res.last_of_message;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = first_q;
	assign m_tlast  = last_q;

endmodule

>>> design/sync_length_frame_parser.sv
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata = rx_byte
// m_       out  m_tvalid/m_tready  m_tdata = payload_byte, m_tuser = first, m_tlast = last
// apb      in   psel/penable       sig_value @0x0, sig_len @0x4, len_field_bytes @0x8
//
// one byte per cycle sustained while the master side is not stalled; the result of a byte
// shows on the master side the cycle after the core processes it
// arst_n clears the phase, counters, window and both valid flags
// a stalled master side holds the core; the input register still takes one byte
// top level of the sync/length frame parser; depends on slfp_pkg and all slfp_ modules

module sync_length_frame_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,   // [7:0] payload_byte
	output logic                              m_tuser,   // [0] first_of_message
	output logic                              m_tlast,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [slfp_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [slfp_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [slfp_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	slfp_pkg::cfg_t              cfg;
	slfp_pkg::res_t              res;
	logic                        valid_s1;
	logic [slfp_pkg::BYTE_W-1:0] byte_s1;
	logic                        out_free;
	logic                        advance;

	assign advance = valid_s1 && out_free;

	slfp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	slfp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	slfp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step_en (advance),
		.rx_byte (byte_s1),
		.res     (res)
	);

	slfp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.advance  (advance),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
